FILE: hw/rtl/sgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient direction package
// Shared types and constants for the Sobel gradient direction block.
// ----------------------------------------------------------------------------
package sgd_pkg;

    localparam int CFG_W = 11;
    localparam int PIX_W = 8;
    localparam int MAG_W = 11;
    localparam int DIR_W = 2;
    localparam int GRAD_W = 12;
    localparam int PROD_W = 22;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic REG_FRAME_WIDTH = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIR_W-1:0] DIR_0 = 2'd0;
    localparam logic [DIR_W-1:0] DIR_45 = 2'd1;
    localparam logic [DIR_W-1:0] DIR_90 = 2'd2;
    localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

    localparam int TAN_LO_NUM = 414;
    localparam int TAN_HI_NUM = 2414;
    localparam int TAN_DEN = 1000;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t win;
        logic    r1;
        logic    r2;
        logic    sel1;
        logic    w1;
        logic    eof;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

endpackage

FILE: hw/rtl/sgd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel front end
// Tracks the frame position, keeps the two line stores and the 3x3 window,
// and hands one queue entry per result-producing transaction to the back end.
// ----------------------------------------------------------------------------
module sgd_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      op,
    input  logic [sgd_pkg::PIX_W-1:0] pixel_value,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [sgd_pkg::CFG_W-1:0] cfg_data,
    output sgd_pkg::push_t            push,
    output logic                      busy
);
    import sgd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic             flushing_reg;
    logic [CW-1:0]    wm1;
    logic [RW-1:0]    hm1;
    logic             work;
    logic             last_col;
    logic             produce;

    logic             b_valid_reg;
    logic             b_op_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [CW-1:0]    b_addr_reg;
    logic             b_r1_reg;
    logic             b_r2_reg;
    logic             b_sel1_reg;
    logic             b_w1_reg;
    logic             b_h1_reg;
    logic             b_row1_reg;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] older_rd_reg;
    logic [PIX_W-1:0] newer_rd_reg;
    logic             wr_en;
    logic             fwd;

    logic [PIX_W-1:0] top_pix;
    logic [PIX_W-1:0] mid_pix;
    logic [PIX_W-1:0] bot_pix;
    window_t          win_reg;
    window_t          win_next;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(32'(frame_width_reg) - 32'd1);
        end
        if (frame_height_reg == '0)
        begin
            hm1 = '0;
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = RW'(32'(frame_height_reg) - 32'd1);
        end
    end

    assign work = accept && ((op == OP_PIXEL && !flushing_reg) ||
                             (op == OP_FLUSH && flushing_reg));
    assign last_col = (col_reg == wm1);
    assign produce = (op == OP_FLUSH) || (row_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            flushing_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg <= frame_width_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
            flushing_reg <= 1'b0;
        end
        else if (work)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                if (op == OP_FLUSH)
                begin
                    flushing_reg <= 1'b0;
                    row_reg <= '0;
                end
                else if (row_reg == hm1)
                begin
                    row_reg <= '0;
                    flushing_reg <= 1'b1;
                end
                else
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= work;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            b_op_reg <= op;
            b_pix_reg <= pixel_value;
            b_addr_reg <= col_reg;
            b_r1_reg <= produce && (col_reg != '0);
            b_r2_reg <= produce && last_col;
            b_sel1_reg <= (col_reg == CW'(1));
            b_w1_reg <= (wm1 == '0);
            b_h1_reg <= (hm1 == '0);
            b_row1_reg <= (row_reg == RW'(1));
        end
    end

    // Line stores: written in the cycle after the read; a read of the address
    // being written in the same cycle takes the new data.
    assign wr_en = b_valid_reg && (b_op_reg == OP_PIXEL);
    assign fwd = wr_en && (b_addr_reg == col_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[b_addr_reg] <= mid_pix;
            newer_mem[b_addr_reg] <= b_pix_reg;
        end
        if (work)
        begin
            older_rd_reg <= fwd ? mid_pix : older_mem[col_reg];
            newer_rd_reg <= fwd ? b_pix_reg : newer_mem[col_reg];
        end
    end

    always_comb
    begin
        mid_pix = newer_rd_reg;
        if (b_op_reg == OP_PIXEL)
        begin
            top_pix = b_row1_reg ? newer_rd_reg : older_rd_reg;
            bot_pix = b_pix_reg;
        end
        else
        begin
            top_pix = b_h1_reg ? newer_rd_reg : older_rd_reg;
            bot_pix = newer_rd_reg;
        end
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_pix;
        win_next[1][2] = mid_pix;
        win_next[2][2] = bot_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (b_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        push.valid = b_valid_reg && (b_r1_reg || b_r2_reg);
        push.entry.win = win_next;
        push.entry.r1 = b_r1_reg;
        push.entry.r2 = b_r2_reg;
        push.entry.sel1 = b_sel1_reg;
        push.entry.w1 = b_w1_reg;
        push.entry.eof = (b_op_reg == OP_FLUSH);
    end

    assign busy = b_valid_reg;

endmodule

FILE: hw/rtl/sgd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel window queue
// Short FIFO of window entries between the front end and the back end.
// ----------------------------------------------------------------------------
module sgd_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sgd_pkg::push_t             push,
    input  logic                       pop,
    output sgd_pkg::entry_t            head,
    output logic                       nonempty,
    output logic [sgd_pkg::QCNT_W-1:0] count
);
    import sgd_pkg::*;

    entry_t            slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push.valid && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push.valid)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assign head = slots_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign count = count_reg;

endmodule

FILE: hw/rtl/sgd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel back end
// Expands each queue entry into one or two results and computes the
// gradient magnitude and quantized direction in a three-stage pipeline.
// ----------------------------------------------------------------------------
module sgd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sgd_pkg::entry_t           head,
    input  logic                      nonempty,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [sgd_pkg::MAG_W-1:0] magnitude,
    output logic [sgd_pkg::DIR_W-1:0] direction,
    output logic                      last_in_run,
    output logic                      end_of_frame
);
    import sgd_pkg::*;

    logic              adv;
    logic              issue;
    logic              second;
    logic              finish;
    logic              part_reg;
    logic [1:0]        cl;
    logic [1:0]        cm;
    logic [PIX_W+1:0]  sum_r;
    logic [PIX_W+1:0]  sum_l;
    logic [PIX_W+1:0]  sum_b;
    logic [PIX_W+1:0]  sum_t;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;

    logic                     s1_valid_reg;
    logic signed [GRAD_W-1:0] s1_gx_reg;
    logic signed [GRAD_W-1:0] s1_gy_reg;
    logic                     s1_last_reg;
    logic                     s1_eof_reg;
    logic signed [GRAD_W-1:0] ngx;
    logic signed [GRAD_W-1:0] ngy;

    logic             s2_valid_reg;
    logic [MAG_W-1:0] s2_ax_reg;
    logic [MAG_W-1:0] s2_ay_reg;
    logic             s2_same_reg;
    logic             s2_last_reg;
    logic             s2_eof_reg;

    logic [PROD_W-1:0] ay_den;
    logic [PROD_W-1:0] ax_lo;
    logic [PROD_W-1:0] ax_hi;
    logic [DIR_W-1:0]  dir_next;

    logic             out_valid_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [DIR_W-1:0] dir_reg;
    logic             last_reg;
    logic             eof_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign issue = adv && nonempty;
    assign second = part_reg || !head.r1;
    assign finish = second || !head.r2;
    assign pop = issue && finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= 1'b0;
        end
        else if (issue)
        begin
            part_reg <= !finish;
        end
    end

    always_comb
    begin
        if (second)
        begin
            cl = head.w1 ? 2'd2 : 2'd1;
            cm = 2'd2;
        end
        else
        begin
            cl = head.sel1 ? 2'd1 : 2'd0;
            cm = 2'd1;
        end
        sum_r = {2'b00, head.win[0][2]} + {1'b0, head.win[1][2], 1'b0} +
                {2'b00, head.win[2][2]};
        sum_l = {2'b00, head.win[0][cl]} + {1'b0, head.win[1][cl], 1'b0} +
                {2'b00, head.win[2][cl]};
        sum_b = {2'b00, head.win[2][cl]} + {1'b0, head.win[2][cm], 1'b0} +
                {2'b00, head.win[2][2]};
        sum_t = {2'b00, head.win[0][cl]} + {1'b0, head.win[0][cm], 1'b0} +
                {2'b00, head.win[0][2]};
        gx = $signed({2'b00, sum_r}) - $signed({2'b00, sum_l});
        gy = $signed({2'b00, sum_b}) - $signed({2'b00, sum_t});
    end

    assign ngx = -s1_gx_reg;
    assign ngy = -s1_gy_reg;

    assign ay_den = PROD_W'(s2_ay_reg) * PROD_W'(TAN_DEN);
    assign ax_lo = PROD_W'(s2_ax_reg) * PROD_W'(TAN_LO_NUM);
    assign ax_hi = PROD_W'(s2_ax_reg) * PROD_W'(TAN_HI_NUM);

    always_comb
    begin
        if (ay_den <= ax_lo)
        begin
            dir_next = DIR_0;
        end
        else if (ay_den >= ax_hi)
        begin
            dir_next = DIR_90;
        end
        else if (s2_same_reg)
        begin
            dir_next = DIR_45;
        end
        else
        begin
            dir_next = DIR_135;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_gx_reg <= gx;
            s1_gy_reg <= gy;
            s1_last_reg <= finish;
            s1_eof_reg <= second && head.eof;

            s2_ax_reg <= s1_gx_reg[GRAD_W-1] ? ngx[MAG_W-1:0] : s1_gx_reg[MAG_W-1:0];
            s2_ay_reg <= s1_gy_reg[GRAD_W-1] ? ngy[MAG_W-1:0] : s1_gy_reg[MAG_W-1:0];
            s2_same_reg <= (s1_gx_reg[GRAD_W-1] == s1_gy_reg[GRAD_W-1]);
            s2_last_reg <= s1_last_reg;
            s2_eof_reg <= s1_eof_reg;

            mag_reg <= s2_ax_reg + s2_ay_reg;
            dir_reg <= dir_next;
            last_reg <= s2_last_reg;
            eof_reg <= s2_eof_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign direction = dir_reg;
    assign last_in_run = last_reg;
    assign end_of_frame = eof_reg;

endmodule

FILE: hw/rtl/sobel_gradient_direction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient direction
// Streaming 3x3 Sobel filter with edge replication that reports the L1
// gradient magnitude and a four-way quantized direction for every pixel.
//
// Channel   Handshake                 Payload
// in        in_valid / in_stall       op, pixel_value
// out       out_valid / out_stall     magnitude, direction, last_in_run,
//                                     end_of_frame
// cfg       cfg_we                    cfg_index, cfg_data
//
// One input transaction is taken per clock while in_stall is low; a row-end
// transaction can make two results, which the four-entry window queue absorbs.
// Results pass through the front-stage, window-queue, s1, s2 and output registers.
// Input is stalled while queued entries plus the one in the front stage
// reach the queue depth; output stalls hold the back-end pipeline.
// Reset is immediate: the line stores need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_gradient_direction #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic [sgd_pkg::PIX_W-1:0] pixel_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [sgd_pkg::MAG_W-1:0] magnitude,
    output logic [sgd_pkg::DIR_W-1:0] direction,
    output logic                      last_in_run,
    output logic                      end_of_frame,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [sgd_pkg::CFG_W-1:0] cfg_data
);
    import sgd_pkg::*;

    logic              accept;
    logic              busy;
    logic              pop;
    logic              nonempty;
    logic [QCNT_W-1:0] count;
    push_t             push;
    entry_t            head;

    assign in_stall = (QCNT_W'(count + QCNT_W'(busy)) >= QCNT_W'(QDEPTH));
    assign accept = in_valid && !in_stall;

    sgd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .pixel_value (pixel_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .busy        (busy)
    );

    sgd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .count    (count)
    );

    sgd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .nonempty     (nonempty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .magnitude    (magnitude),
        .direction    (direction),
        .last_in_run  (last_in_run),
        .end_of_frame (end_of_frame)
    );

endmodule

FILE: hw/rtl/sgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient direction checker
// Port-level assertions on the result channel of the Sobel block.
// ----------------------------------------------------------------------------
module sgd_port_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [sgd_pkg::MAG_W-1:0] magnitude,
    input logic [sgd_pkg::DIR_W-1:0] direction,
    input logic                      last_in_run,
    input logic                      end_of_frame
);
    import sgd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(magnitude) &&
        $stable(direction) && $stable(last_in_run) && $stable(end_of_frame))
        else $error("Stalled result transaction changed.");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> magnitude <= 11'd2040)
        else $error("Magnitude above the largest possible gradient.");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_in_run)
        else $error("Frame end result is not the last of its run.");

    a_flat_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && magnitude == '0 |-> direction == DIR_0)
        else $error("Flat window reported a nonzero direction.");

endmodule

bind sobel_gradient_direction sgd_port_checker u_sgd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .magnitude    (magnitude),
    .direction    (direction),
    .last_in_run  (last_in_run),
    .end_of_frame (end_of_frame)
);

FILE: tb/sgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient direction checker
// Watches the input, output and register write ports of the Sobel gradient
// block. Each accepted input transaction is run through a local model of the
// line stores and the 3x3 window. The model queues the results it expects,
// and every accepted output transaction is compared field by field with the
// oldest of them. The number of mismatches and the number of results still
// due are passed to the testbench top.
// ----------------------------------------------------------------------------
module sgd_checker #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      op,
    input  logic [sgd_pkg::PIX_W-1:0] pixel_value,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [sgd_pkg::MAG_W-1:0] magnitude,
    input  logic [sgd_pkg::DIR_W-1:0] direction,
    input  logic                      last_in_run,
    input  logic                      end_of_frame,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [sgd_pkg::CFG_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        outstanding
);

    import sgd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [DIR_W-1:0] direction;
        logic             last_in_run;
        logic             end_of_frame;
    } gradient_t;

    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] lower_line [MAX_WIDTH];
    logic [PIX_W-1:0] window [3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    bit               flushing;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    gradient_t        gradient_q [$];

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    function automatic int pel(int r, int c);
        int v;
        v = window[r][c];
        return v;
    endfunction

    function automatic void slide(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                  logic [PIX_W-1:0] b);
        for (int i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = t;
        window[1][2] = m;
        window[2][2] = b;
    endfunction

    function automatic gradient_t sobel_at(int cl, int cm, int cr);
        gradient_t g;
        int gx;
        int gy;
        int ax;
        int ay;
        gx = (pel(0, cr) + 2 * pel(1, cr) + pel(2, cr)) -
             (pel(0, cl) + 2 * pel(1, cl) + pel(2, cl));
        gy = (pel(2, cl) + 2 * pel(2, cm) + pel(2, cr)) -
             (pel(0, cl) + 2 * pel(0, cm) + pel(0, cr));
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        g = '0;
        g.magnitude = MAG_W'(ax + ay);
        if (ay * TAN_DEN <= ax * TAN_LO_NUM)
            g.direction = DIR_0;
        else if (ay * TAN_DEN >= ax * TAN_HI_NUM)
            g.direction = DIR_90;
        else if ((gx >= 0) == (gy >= 0))
            g.direction = DIR_45;
        else
            g.direction = DIR_135;
        return g;
    endfunction

    function automatic void take_item(logic item_op, logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit               produce;
        gradient_t        run [2];
        int               n;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        n = 0;
        if (item_op == OP_PIXEL)
        begin
            if (flushing)
                return;
            up = upper_line[AW'(c)];
            mid = lower_line[AW'(c)];
            upper_line[AW'(c)] = mid;
            lower_line[AW'(c)] = pix;
            if (row_pos == 1)
                up = mid;
            slide(up, mid, pix);
            produce = (row_pos >= 1);
        end
        else
        begin
            if (!flushing)
                return;
            mid = lower_line[AW'(c)];
            up = (h == 1) ? mid : upper_line[AW'(c)];
            slide(up, mid, mid);
            produce = 1'b1;
        end
        if (produce)
        begin
            if (c >= 1)
            begin
                run[n] = sobel_at((c == 1) ? 1 : 0, 1, 2);
                n++;
            end
            if (c == w - 1)
            begin
                run[n] = sobel_at((w == 1) ? 2 : 1, 2, 2);
                run[n].end_of_frame = (item_op == OP_FLUSH);
                n++;
            end
            if (n > 0)
                run[n - 1].last_in_run = 1'b1;
            for (int i = 0; i < n; i++)
                gradient_q.push_back(run[i]);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            if (item_op == OP_FLUSH)
            begin
                flushing = 1'b0;
                row_pos = 0;
            end
            else
            begin
                row_pos++;
                if (row_pos >= h)
                begin
                    row_pos = 0;
                    flushing = 1'b1;
                end
            end
        end
        col_pos = c;
    endfunction

    function automatic void note(string what, logic [15:0] want_v, logic [15:0] got_v);
        $display("%0t: %s expected %0d, actual %0d", $time, what, want_v, got_v);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        gradient_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_line[AW'(i)] = '0;
                lower_line[AW'(i)] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    window[r][c] = '0;
            row_pos = 0;
            col_pos = 0;
            flushing = 1'b0;
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            gradient_q.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (gradient_q.size() == 0)
                begin
                    $display("%0t: result expected none, actual magnitude %0d direction %0d",
                             $time, magnitude, direction);
                    mismatches++;
                end
                else
                begin
                    want = gradient_q.pop_front();
                    if (magnitude !== want.magnitude)
                        note("magnitude", 16'(want.magnitude), 16'(magnitude));
                    if (direction !== want.direction)
                        note("direction", 16'(want.direction), 16'(direction));
                    if (last_in_run !== want.last_in_run)
                        note("last_in_run", 16'(want.last_in_run), 16'(last_in_run));
                    if (end_of_frame !== want.end_of_frame)
                        note("end_of_frame", 16'(want.end_of_frame), 16'(end_of_frame));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                row_pos = 0;
                col_pos = 0;
                flushing = 1'b0;
            end
            if (in_valid && !in_stall)
                take_item(op, pixel_value);
            outstanding = gradient_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient direction testbench
// Drives pixel frames and flush transactions into the Sobel gradient block
// under random sender gaps and receiver stalls, with two long receiver
// hold-offs that back the block up. A short directed sequence covers the
// pixel extremes and the smallest frame sizes, then short partial frames at
// the largest and clamped sizes, then random small frames with edge, flat,
// binary and noise scenes, stray transactions and aborted frames. The checker
// instance predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    import sgd_pkg::*;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RANDOM_ITEMS = 380;
    localparam int PROBE_ITEMS = 30;

    typedef enum int {
        SCENE_NOISE,
        SCENE_VEDGE,
        SCENE_HEDGE,
        SCENE_DIAG,
        SCENE_ANTI,
        SCENE_FLAT,
        SCENE_BINARY
    } scene_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             op;
    logic [PIX_W-1:0] pixel_value;
    logic             out_valid;
    logic             out_stall;
    logic [MAG_W-1:0] magnitude;
    logic [DIR_W-1:0] direction;
    logic             last_in_run;
    logic             end_of_frame;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               outstanding;

    bit               rush;
    bit               settle;
    int               width_now;
    int               height_now;
    int               frame_items;
    int               knob;
    logic [PIX_W-1:0] dark;
    logic [PIX_W-1:0] bright;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    sobel_gradient_direction #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .magnitude   (magnitude),
        .direction   (direction),
        .last_in_run (last_in_run),
        .end_of_frame(end_of_frame),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    sgd_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) gradient_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .magnitude   (magnitude),
        .direction   (direction),
        .last_in_run (last_in_run),
        .end_of_frame(end_of_frame),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [PIX_W-1:0] scene_pixel(scene_t s, int r, int c);
        case (s)
            SCENE_VEDGE:  return (c < knob) ? dark : bright;
            SCENE_HEDGE:  return (r < knob) ? dark : bright;
            SCENE_DIAG:   return (r + c < knob) ? dark : bright;
            SCENE_ANTI:   return (c - r + height_now < knob) ? dark : bright;
            SCENE_FLAT:   return dark;
            SCENE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default:      return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(logic item_op, logic [PIX_W-1:0] item_pixel);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= item_op;
        pixel_value <= item_pixel;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
        int eff;
        eff = (v == 0) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_now = eff;
        else
            height_now = eff;
    endtask

    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        settle = 1'b1;
        repeat (12) @(negedge clk);
        settle = 1'b0;
    endtask

    task automatic run_frame(scene_t s, bit noisy, int stop_at);
        int k;
        k = 0;
        knob = $urandom_range(0, width_now + height_now);
        case ($urandom_range(0, 2))
            0:
            begin
                dark = 8'h00;
                bright = 8'hFF;
            end
            1:
            begin
                dark = 8'hFF;
                bright = 8'h00;
            end
            default:
            begin
                dark = PIX_W'($urandom_range(0, 255));
                bright = PIX_W'($urandom_range(0, 255));
            end
        endcase
        for (int r = 0; r < height_now; r++)
            for (int c = 0; c < width_now; c++)
            begin
                if (k == stop_at)
                    return;
                if (noisy && $urandom_range(0, 15) == 0)
                    send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
                send_item(OP_PIXEL, scene_pixel(s, r, c));
                k++;
                frame_items++;
            end
        for (int c = 0; c < width_now; c++)
        begin
            if (k == stop_at)
                return;
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
            send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
            k++;
            frame_items++;
        end
    endtask

    initial
    begin : stimulus
        int w_pick;
        int h_pick;
        int frames;
        int stop;
        bit first;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_PIXEL;
        pixel_value = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        rush = 1'b0;
        settle = 1'b0;
        width_now = FRAME_WIDTH_RESET;
        height_now = FRAME_HEIGHT_RESET;
        frame_items = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_FLUSH, 8'hFF);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h80);
        repeat (3) send_item(OP_FLUSH, 8'h00);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_FLUSH, 8'h00);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_FLUSH, 8'hFF);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd2);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h00);
        repeat (2) send_item(OP_FLUSH, 8'h00);

        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd1024);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        rush = ($urandom_range(0, 1) != 0);
        run_frame(scene_t'($urandom_range(0, 6)), 1'b0, PROBE_ITEMS);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd2047);
        rush = ($urandom_range(0, 1) != 0);
        run_frame(scene_t'($urandom_range(0, 6)), 1'b0, PROBE_ITEMS);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1024);
        rush = ($urandom_range(0, 1) != 0);
        run_frame(scene_t'($urandom_range(0, 6)), 1'b0, PROBE_ITEMS);
        quiesce();
        write_reg(REG_FRAME_HEIGHT, 11'd2047);
        rush = ($urandom_range(0, 1) != 0);
        run_frame(scene_t'($urandom_range(0, 6)), 1'b0, PROBE_ITEMS);

        frame_items = 0;
        first = 1'b1;
        while (frame_items < RANDOM_ITEMS)
        begin
            quiesce();
            w_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(0, 12);
            h_pick = $urandom_range(0, 5);
            case (first ? 2 : $urandom_range(0, 3))
                0: write_reg(REG_FRAME_WIDTH, CFG_W'(w_pick));
                1: write_reg(REG_FRAME_HEIGHT, CFG_W'(h_pick));
                2:
                begin
                    write_reg(REG_FRAME_WIDTH, CFG_W'(w_pick));
                    write_reg(REG_FRAME_HEIGHT, CFG_W'(h_pick));
                end
                default:
                begin
                    write_reg(REG_FRAME_HEIGHT, CFG_W'(h_pick));
                    write_reg(REG_FRAME_WIDTH, CFG_W'(w_pick));
                end
            endcase
            first = 1'b0;
            rush = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++)
            begin
                stop = -1;
                if (f == frames - 1 && $urandom_range(0, 7) == 0)
                    stop = $urandom_range(0, width_now * height_now + width_now - 1);
                run_frame(scene_t'($urandom_range(0, 6)), 1'b1, stop);
            end
        end

        quiesce();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : receiver
        int gap;
        int n;
        int got;
        bit eager;
        got = 0;
        eager = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                eager = !eager;
            if (got == 60 || got == 300)
                gap = 150;
            else
                gap = eager ? 0 : $urandom_range(0, 11);
            if (settle)
                gap = 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                n = 0;
                while (n < gap && !settle)
                begin
                    @(negedge clk);
                    n++;
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got++;
        end
    end

endmodule
